FILE: hdl/priority_voice_allocator_core_macros.svh
// Assertion macros used by the voice allocator RTL.
`ifndef PRIORITY_VOICE_ALLOCATOR_CORE_MACROS_SVH
`define PRIORITY_VOICE_ALLOCATOR_CORE_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define PVA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PVA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hdl/pva_pkg.sv
// Types and codes of the priority voice allocator.
`default_nettype none

package pva_pkg;

    localparam int CH_W   = 4;
    localparam int PRIO_W = 8;
    localparam int FMT_W  = 2;
    localparam int FUNC_W = 2;
    localparam int MASK_W = 64;
    localparam int FMT_PER_CH = 4;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FINISH  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [CH_W-1:0]   target_channel;
        logic [FMT_W-1:0]  request_format;
        logic [PRIO_W-1:0] request_priority;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [CH_W-1:0]   granted_channel;
        logic              preempted;
        logic [PRIO_W-1:0] preempted_priority;
    } t_result;

    // Search record handed from cell to cell.
    typedef struct packed {
        logic              found_free;
        logic              found_low;
        logic [CH_W-1:0]   ch;
        logic [PRIO_W-1:0] low_prio;
    } t_scan;

    // State update broadcast to all cells.
    typedef struct packed {
        logic              en;
        logic [FUNC_W-1:0] op;
        logic [CH_W-1:0]   ch;
        logic [PRIO_W-1:0] prio;
    } t_cell_cmd;

endpackage

`default_nettype wire

FILE: hdl/pva_cell.sv
// One channel cell: holds busy, finished and priority; updates the search record.
`default_nettype none

module pva_cell
    import pva_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tok,
    input  wire t_scan             i_rec,
    input  wire logic              i_elig,
    input  wire logic [PRIO_W-1:0] i_req_prio,
    input  wire t_cell_cmd         i_cmd,
    output logic                   o_tok,
    output t_scan                  o_rec
);

    logic              r_busy;
    logic              r_done;
    logic [PRIO_W-1:0] r_prio;
    logic              r_tok;
    t_scan             r_rec;
    t_scan             n_rec;
    logic              w_hit;

    // Fold this channel into the record; first free channel wins outright.
    always_comb begin
        n_rec = i_rec;
        if (!i_rec.found_free && i_elig) begin
            if (!r_busy || r_done) begin
                n_rec.found_free = 1'b1;
                n_rec.ch         = CH_W'(CELL_IDX);
            end else if (r_prio < i_req_prio &&
                         (!i_rec.found_low || r_prio < i_rec.low_prio)) begin
                n_rec.found_low = 1'b1;
                n_rec.ch        = CH_W'(CELL_IDX);
                n_rec.low_prio  = r_prio;
            end
        end
    end

    assign w_hit = i_cmd.en && (i_cmd.ch == CH_W'(CELL_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_prio <= '0;
            r_tok  <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (w_hit) begin
                unique case (i_cmd.op)
                    FUNC_ALLOC: begin
                        r_busy <= 1'b1;
                        r_done <= 1'b0;
                        r_prio <= i_cmd.prio;
                    end
                    FUNC_RELEASE: begin
                        r_busy <= 1'b0;
                        r_done <= 1'b0;
                        r_prio <= '0;
                    end
                    FUNC_FINISH: begin
                        r_done <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Record is payload; advance it with the token.
    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_rec <= n_rec;
        end
    end

    assign o_tok = r_tok;
    assign o_rec = r_rec;

endmodule

`default_nettype wire

FILE: hdl/priority_voice_allocator_core.sv
// Top level of the priority voice allocator: request port, mask register, cell chain.
//
//  channel   | direction | handshake                      | payload
//  ----------+-----------+--------------------------------+-------------------------
//  request   | in        | start, taken when busy is low  | i_cmd (t_req)
//  result    | out       | o_result_valid, one cycle      | o_result (t_result)
//  config    | in        | i_cfg_we, taken at once        | i_cfg_wdata (mask)
//
//  Allocate: the search token walks the chain one cell per cycle, through
//  the launch register and each cell's token register; busy rises on accept
//  and falls as the token leaves the last cell. Release, finished and the unused
//  code give their result in the next cycle and leave busy low.
//  Reset (synchronous, active low) idles every channel, zeroes priorities
//  and sets the format mask to all ones. The receiver cannot stall results.
`default_nettype none

`include "priority_voice_allocator_core_macros.svh"

module priority_voice_allocator_core
    import pva_pkg::*;
#(
    parameter int NUM_CHANNELS = 16,
    parameter int NUM_FORMATS  = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire t_req              i_cmd,
    output logic                   o_result_valid,
    output t_result                o_result,
    input  wire logic              i_cfg_we,
    input  wire logic [MASK_W-1:0] i_cfg_wdata
);

    // Configuration: per-channel format support, four bits per channel.
    logic [MASK_W-1:0] r_mask;

    // Held allocate request, broadcast to every cell during the scan.
    logic [FMT_W-1:0]  r_req_fmt;
    logic [PRIO_W-1:0] r_req_prio;

    logic r_busy;
    logic r_launch;
    logic r_res_vld;
    t_result r_result;
    t_result n_result;

    logic w_accept;
    logic w_fmt_ok;
    logic w_scan_end;
    t_cell_cmd w_cmd;

    // Chain wiring: slot 0 feeds the first cell, slot NUM_CHANNELS is the tail.
    logic  w_tok [0:NUM_CHANNELS];
    t_scan w_rec [0:NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] w_elig;
    logic [NUM_CHANNELS-1:0] w_tok_vec;
    logic [NUM_CHANNELS-1:0][FMT_PER_CH-1:0] w_fmt_bits;

    assign w_accept = start && !busy;
    assign busy     = r_busy;

    // A format at or past NUM_FORMATS matches no channel.
    assign w_fmt_ok = ({1'b0, r_req_fmt} < (FMT_W + 1)'(NUM_FORMATS));

    assign w_tok[0] = r_launch;
    assign w_rec[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_CHANNELS; g++) begin : g_cell
            assign w_fmt_bits[g] = r_mask[g*FMT_PER_CH +: FMT_PER_CH];
            assign w_elig[g]     = w_fmt_ok && w_fmt_bits[g][r_req_fmt];
            assign w_tok_vec[g]  = w_tok[g+1];

            pva_cell #(
                .CELL_IDX (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_tok      (w_tok[g]),
                .i_rec      (w_rec[g]),
                .i_elig     (w_elig[g]),
                .i_req_prio (r_req_prio),
                .i_cmd      (w_cmd),
                .o_tok      (w_tok[g+1]),
                .o_rec      (w_rec[g+1])
            );
        end
    endgenerate

    // The token leaving the last cell carries the final search record.
    assign w_scan_end = w_tok[NUM_CHANNELS];

    // Result of a finished scan: free channel first, otherwise steal the
    // lowest-priority busy channel found below the request.
    always_comb begin
        n_result = '0;
        if (w_rec[NUM_CHANNELS].found_free || w_rec[NUM_CHANNELS].found_low) begin
            n_result.granted         = 1'b1;
            n_result.granted_channel = w_rec[NUM_CHANNELS].ch;
            if (!w_rec[NUM_CHANNELS].found_free) begin
                n_result.preempted          = 1'b1;
                n_result.preempted_priority = w_rec[NUM_CHANNELS].low_prio;
            end
        end
    end

    // State update to the cells: release and finished apply on accept,
    // a grant applies when the scan ends. The two never coincide.
    always_comb begin
        w_cmd = '0;
        priority if (w_accept && i_cmd.func != FUNC_ALLOC) begin
            w_cmd.en = 1'b1;
            w_cmd.op = i_cmd.func;
            w_cmd.ch = i_cmd.target_channel;
        end else if (w_scan_end) begin
            w_cmd.en   = n_result.granted;
            w_cmd.op   = FUNC_ALLOC;
            w_cmd.ch   = n_result.granted_channel;
            w_cmd.prio = r_req_prio;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '1;
            r_busy    <= 1'b0;
            r_launch  <= 1'b0;
            r_res_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            r_launch  <= w_accept && i_cmd.func == FUNC_ALLOC;
            r_res_vld <= (w_accept && i_cmd.func != FUNC_ALLOC) || w_scan_end;
            priority if (w_accept && i_cmd.func == FUNC_ALLOC) begin
                r_busy <= 1'b1;
            end else if (w_scan_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Payload: hold the request during the scan, latch the result.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_fmt  <= i_cmd.request_format;
            r_req_prio <= i_cmd.request_priority;
        end
        priority if (w_accept) begin
            r_result <= '0;
        end else if (w_scan_end) begin
            r_result <= n_result;
        end
    end

    assign o_result_valid = r_res_vld;
    assign o_result       = r_result;

    // Checks on the scan and result logic.
    `PVA_ASSERT_NEXT(a_alloc_busy, i_clk, i_rst_n, w_accept && i_cmd.func == FUNC_ALLOC, busy, "allocate did not raise busy")
    `PVA_ASSERT_SAME(a_res_idle, i_clk, i_rst_n, o_result_valid, !busy, "result issued while busy")
    `PVA_ASSERT_SAME(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0({r_launch, w_tok_vec}), "more than one scan token")
    `PVA_ASSERT_SAME(a_refused_zero, i_clk, i_rst_n, o_result_valid && !o_result.granted, o_result.granted_channel == '0 && !o_result.preempted && o_result.preempted_priority == '0, "refused result not zero")
    `PVA_ASSERT_SAME(a_preempt_grant, i_clk, i_rst_n, o_result_valid && o_result.preempted, o_result.granted, "preempt without grant")

endmodule

`default_nettype wire
